FILE: sv/servo_bus_packet_deframer_macros.svh
// assertion macros shared by the deframer modules
`ifndef SERVO_BUS_PACKET_DEFRAMER_MACROS_SVH
`define SERVO_BUS_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbpd assertion failed");

// next-cycle implication, checked out of reset
`define SBPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbpd assertion failed");

`endif

FILE: sv/sbpd_pkg.sv
// types, codes and constants of the servo bus packet deframer
package sbpd_pkg;

    // largest accepted length byte
    localparam int MAX_LENGTH  = 64;
    localparam int STORE_DEPTH = MAX_LENGTH - 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LEN_W       = $clog2(MAX_LENGTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd4000;
    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;

    // input commands
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_BADLEN  = 2'd2;
    localparam logic [1:0] STAT_BADSUM  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [5:0] data_limit;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] sender_id;
        logic [7:0] error_flags;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [5:0] data_count;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_PAYLOAD,
        PH_READ,
        PH_PUSH
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic       arm;
        logic       tick_inc;
        logic       hunt;
        logic       take_id;
        logic       take_len;
        logic       take_pay;
        logic       emit_init;
        logic       mem_read;
        logic       emit_next;
        logic       load_fail;
        logic       load_empty;
        logic       load_data;
        logic [1:0] fail_code;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_done;
        logic len_bad;
        logic pay_last;
        logic sum_ok;
        logic time_up;
        logic emit_empty;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/sbpd_ctrl.sv
// control state machine of the servo bus packet deframer
`include "servo_bus_packet_deframer_macros.svh"

module sbpd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  sbpd_pkg::in_item_t    s_item,
    output logic                  s_ready,
    input  sbpd_pkg::dp_status_t  dp_st,
    output sbpd_pkg::dp_cmd_t     dp_cmd
);

    sbpd_pkg::phase_t state_reg, state_next;

    logic active;
    logic take;
    logic take_arm;
    logic take_tick;
    logic take_byte;
    logic expire;
    logic in_read;
    logic in_push;
    logic push_last;

    // item decode
    always_comb begin
        active    = (state_reg == sbpd_pkg::PH_HUNT) || (state_reg == sbpd_pkg::PH_ID) ||
                    (state_reg == sbpd_pkg::PH_LEN) || (state_reg == sbpd_pkg::PH_PAYLOAD);
        s_ready   = (active || (state_reg == sbpd_pkg::PH_IDLE)) && dp_st.out_free;
        take      = s_valid && s_ready;
        take_arm  = take && (s_item.cmd == sbpd_pkg::CMD_ARM);
        take_tick = take && active && (s_item.cmd == sbpd_pkg::CMD_TICK);
        take_byte = take && (s_item.cmd == sbpd_pkg::CMD_BYTE);
        expire    = take_tick && dp_st.time_up;
        in_read   = (state_reg == sbpd_pkg::PH_READ);
        in_push   = (state_reg == sbpd_pkg::PH_PUSH);
        push_last = in_push && dp_st.out_free && dp_st.emit_last;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbpd_pkg::PH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbpd_pkg::PH_IDLE: begin
                if (take_arm) state_next = sbpd_pkg::PH_HUNT;
            end
            sbpd_pkg::PH_HUNT: begin
                if (take_arm) state_next = sbpd_pkg::PH_HUNT;
                else if (expire) state_next = sbpd_pkg::PH_IDLE;
                else if (take_byte && dp_st.hdr_done) state_next = sbpd_pkg::PH_ID;
            end
            sbpd_pkg::PH_ID: begin
                if (take_arm) state_next = sbpd_pkg::PH_HUNT;
                else if (expire) state_next = sbpd_pkg::PH_IDLE;
                else if (take_byte) state_next = sbpd_pkg::PH_LEN;
            end
            sbpd_pkg::PH_LEN: begin
                if (take_arm) state_next = sbpd_pkg::PH_HUNT;
                else if (expire) state_next = sbpd_pkg::PH_IDLE;
                else if (take_byte) begin
                    state_next = dp_st.len_bad ? sbpd_pkg::PH_IDLE : sbpd_pkg::PH_PAYLOAD;
                end
            end
            sbpd_pkg::PH_PAYLOAD: begin
                if (take_arm) state_next = sbpd_pkg::PH_HUNT;
                else if (expire) state_next = sbpd_pkg::PH_IDLE;
                else if (take_byte && dp_st.pay_last) begin
                    if (!dp_st.sum_ok || dp_st.emit_empty) state_next = sbpd_pkg::PH_IDLE;
                    else state_next = sbpd_pkg::PH_READ;
                end
            end
            sbpd_pkg::PH_READ: begin
                state_next = sbpd_pkg::PH_PUSH;
            end
            sbpd_pkg::PH_PUSH: begin
                if (dp_st.out_free) begin
                    state_next = dp_st.emit_last ? sbpd_pkg::PH_IDLE : sbpd_pkg::PH_READ;
                end
            end
            default: state_next = sbpd_pkg::PH_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        dp_cmd          = '0;
        dp_cmd.arm      = take_arm;
        dp_cmd.tick_inc = take_tick && !dp_st.time_up;
        if (expire) begin
            dp_cmd.load_fail = 1'b1;
            dp_cmd.fail_code = sbpd_pkg::STAT_TIMEOUT;
        end
        unique case (state_reg)
            sbpd_pkg::PH_HUNT: begin
                dp_cmd.hunt = take_byte;
            end
            sbpd_pkg::PH_ID: begin
                dp_cmd.take_id = take_byte;
            end
            sbpd_pkg::PH_LEN: begin
                if (take_byte) begin
                    if (dp_st.len_bad) begin
                        dp_cmd.load_fail = 1'b1;
                        dp_cmd.fail_code = sbpd_pkg::STAT_BADLEN;
                    end else begin
                        dp_cmd.take_len = 1'b1;
                    end
                end
            end
            sbpd_pkg::PH_PAYLOAD: begin
                if (take_byte) begin
                    if (!dp_st.pay_last) begin
                        dp_cmd.take_pay = 1'b1;
                    end else if (!dp_st.sum_ok) begin
                        dp_cmd.load_fail = 1'b1;
                        dp_cmd.fail_code = sbpd_pkg::STAT_BADSUM;
                    end else begin
                        dp_cmd.emit_init  = 1'b1;
                        dp_cmd.load_empty = dp_st.emit_empty;
                    end
                end
            end
            sbpd_pkg::PH_READ: begin
                dp_cmd.mem_read = 1'b1;
            end
            sbpd_pkg::PH_PUSH: begin
                dp_cmd.load_data = dp_st.out_free;
                dp_cmd.emit_next = dp_st.out_free && !dp_st.emit_last;
            end
            default: begin
                dp_cmd.hunt = 1'b0;
            end
        endcase
    end

    // checks
    `SBPD_ASSERT_NEXT(a_read_then_push, in_read, in_push)
    `SBPD_ASSERT_IMPL(a_no_item_in_burst, in_read || in_push, !s_ready)
    `SBPD_ASSERT_NEXT(a_last_push_idles, push_last, state_reg == sbpd_pkg::PH_IDLE)

endmodule

FILE: sv/sbpd_datapath.sv
// registers, payload memory, checksum and result register of the deframer
`include "servo_bus_packet_deframer_macros.svh"

module sbpd_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  sbpd_pkg::in_item_t    s_item,
    input  sbpd_pkg::dp_cmd_t     dp_cmd,
    output sbpd_pkg::dp_status_t  dp_status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sbpd_pkg::out_item_t   m_item
);

    logic [15:0]                  timeout_reg;
    logic [15:0]                  elapsed_reg;
    logic                         hdr_seen_reg;
    logic [7:0]                   id_reg;
    logic [sbpd_pkg::LEN_W-1:0]   len_reg;
    logic [sbpd_pkg::LEN_W-1:0]   idx_reg;
    logic [7:0]                   sum_reg;
    logic [7:0]                   err_reg;
    logic [5:0]                   limit_reg;
    logic [5:0]                   n_reg;
    logic [5:0]                   k_reg;
    logic [7:0]                   rd_reg;
    logic                         m_valid_reg;
    sbpd_pkg::out_item_t          out_reg;
    sbpd_pkg::out_item_t          out_next;

    logic [7:0] store_mem [sbpd_pkg::STORE_DEPTH];

    logic [7:0]                   b;
    logic [sbpd_pkg::LEN_W:0]     idx_inc;
    logic [sbpd_pkg::LEN_W-1:0]   idx_dec;
    logic [7:0]                   avail;
    logic [7:0]                   n_wide;
    logic [5:0]                   n_comb;
    logic [6:0]                   k_inc;
    logic [sbpd_pkg::ADDR_W-1:0]  wr_addr;
    logic [sbpd_pkg::ADDR_W-1:0]  rd_addr;

    // status toward the controller
    always_comb begin
        b       = s_item.rx_byte;
        idx_inc = {1'b0, idx_reg} + 1'b1;
        idx_dec = idx_reg - 1'b1;
        avail   = 8'(len_reg) - 8'd2;
        n_wide  = avail;
        if (n_wide > 8'(limit_reg)) n_wide = 8'(limit_reg);
        if (n_wide > 8'(sbpd_pkg::STORE_DEPTH)) n_wide = 8'(sbpd_pkg::STORE_DEPTH);
        n_comb  = n_wide[5:0];
        k_inc   = {1'b0, k_reg} + 1'b1;
        wr_addr = sbpd_pkg::ADDR_W'(idx_dec);
        rd_addr = sbpd_pkg::ADDR_W'(k_reg);

        dp_status.hdr_done   = (b == sbpd_pkg::SYNC_BYTE) && hdr_seen_reg;
        dp_status.len_bad    = (b < 8'd2) || (b > 8'(sbpd_pkg::MAX_LENGTH));
        dp_status.pay_last   = idx_inc >= {1'b0, len_reg};
        dp_status.sum_ok     = (~sum_reg) == b;
        dp_status.time_up    = elapsed_reg >= timeout_reg;
        dp_status.emit_empty = (n_comb == '0);
        dp_status.emit_last  = (k_inc == {1'b0, n_reg});
        dp_status.out_free   = !m_valid_reg || m_ready;
    end

    // receive registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= sbpd_pkg::TIMEOUT_RESET;
            elapsed_reg  <= '0;
            hdr_seen_reg <= 1'b0;
            id_reg       <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            err_reg      <= '0;
            limit_reg    <= '0;
        end else begin
            if (cfg_wr_en) timeout_reg <= cfg_wr_data;
            if (dp_cmd.arm) begin
                limit_reg    <= s_item.data_limit;
                elapsed_reg  <= '0;
                hdr_seen_reg <= 1'b0;
                idx_reg      <= '0;
                sum_reg      <= '0;
            end
            if (dp_cmd.tick_inc) elapsed_reg <= elapsed_reg + 16'd1;
            if (dp_cmd.hunt) begin
                hdr_seen_reg <= (b == sbpd_pkg::SYNC_BYTE) && !hdr_seen_reg;
            end
            if (dp_cmd.take_id) id_reg <= b;
            if (dp_cmd.take_len) begin
                len_reg <= sbpd_pkg::LEN_W'(b);
                idx_reg <= '0;
                sum_reg <= id_reg + b;
            end
            if (dp_cmd.take_pay) begin
                if (idx_reg == '0) err_reg <= b;
                sum_reg <= sum_reg + b;
                idx_reg <= idx_inc[sbpd_pkg::LEN_W-1:0];
            end
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (dp_cmd.take_pay && (idx_reg != '0)) store_mem[wr_addr] <= b;
        if (dp_cmd.mem_read) rd_reg <= store_mem[rd_addr];
    end

    // burst counters
    always_ff @(posedge aclk) begin
        if (dp_cmd.emit_init) begin
            n_reg <= n_comb;
            k_reg <= '0;
        end else if (dp_cmd.emit_next) begin
            k_reg <= k_inc[5:0];
        end
    end

    // result item contents
    always_comb begin
        out_next = out_reg;
        if (dp_cmd.load_fail) begin
            out_next        = '0;
            out_next.status = dp_cmd.fail_code;
            out_next.last   = 1'b1;
        end else if (dp_cmd.load_empty) begin
            out_next             = '0;
            out_next.status      = sbpd_pkg::STAT_OK;
            out_next.sender_id   = id_reg;
            out_next.error_flags = err_reg;
            out_next.last        = 1'b1;
        end else if (dp_cmd.load_data) begin
            out_next.status      = sbpd_pkg::STAT_OK;
            out_next.sender_id   = id_reg;
            out_next.error_flags = err_reg;
            out_next.data_byte   = rd_reg;
            out_next.data_valid  = 1'b1;
            out_next.data_count  = n_reg;
            out_next.last        = dp_status.emit_last;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.load_fail || dp_cmd.load_empty || dp_cmd.load_data) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // checks
    `SBPD_ASSERT_NEXT(a_burst_count_nonzero, dp_cmd.emit_init && !dp_status.emit_empty, n_reg != '0)
    `SBPD_ASSERT_IMPL(a_read_in_range, dp_cmd.mem_read, k_reg < n_reg)
    `SBPD_ASSERT_NEXT(a_result_held, m_valid_reg && !m_ready, m_valid_reg && $stable(out_reg))

endmodule

FILE: sv/servo_bus_packet_deframer.sv
// top level of the servo bus status packet deframer
//
//   channel  direction  handshake          payload
//   cfg      in         cfg_wr_en          cfg_wr_data (timeout_ticks)
//   s        in         s_valid / s_ready  s_item (cmd, rx_byte, data_limit)
//   m        out        m_valid / m_ready  m_item (status .. last)
//
// items: one per cycle, but none is taken while a result is unread or during a data burst
// checksum of a good packet with data to send: input held until its last data result loads
// each data result: a payload memory read (PH_READ), then an output register load (PH_PUSH)
// failure or empty success: one result, loaded at the accepting edge
// reset: synchronous, active low; the payload memory needs no clearing
// stalls: a held result blocks input and stretches a burst cycle for cycle
module servo_bus_packet_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sbpd_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sbpd_pkg::out_item_t  m_item
);

    sbpd_pkg::dp_cmd_t    dp_cmd;
    sbpd_pkg::dp_status_t dp_status;

    // sequencing
    sbpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_item  (s_item),
        .s_ready (s_ready),
        .dp_st   (dp_status),
        .dp_cmd  (dp_cmd)
    );

    // storage and arithmetic
    sbpd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule
